>>> rtl/assert_macros.svh
// assertion macros shared by the timer interruptor rtl
// depends on nothing; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CLT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define CLT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/clint_pkg.sv
// types, codes and helpers for the core-local timer interruptor
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package clint_pkg;

   // request kinds
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   // access sizes
   localparam logic [1:0] SIZE_BYTE   = 2'd0;
   localparam logic [1:0] SIZE_HALF   = 2'd1;
   localparam logic [1:0] SIZE_WORD   = 2'd2;
   localparam logic [1:0] SIZE_DOUBLE = 2'd3;

   localparam int PEND_W = 4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] addr;
      logic [1:0]  access_size;
      logic        sign_extend;
      logic [63:0] write_data;
   } req_payload_type;

   typedef struct packed {
      logic [63:0]       read_data;
      logic [PEND_W-1:0] soft_pending;
      logic [PEND_W-1:0] timer_pending;
   } rsp_payload_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic cmp;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
   } dp_status_type;

   function automatic logic [63:0] size_mask(input logic [1:0] size);
      logic [63:0] m;
      unique case (size)
         SIZE_BYTE:   m = 64'h0000_0000_0000_00ff;
         SIZE_HALF:   m = 64'h0000_0000_0000_ffff;
         SIZE_WORD:   m = 64'h0000_0000_ffff_ffff;
         SIZE_DOUBLE: m = 64'hffff_ffff_ffff_ffff;
         default:     m = 64'hffff_ffff_ffff_ffff;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

>>> rtl/clint_ctrl.sv
// controller state machine for the timer interruptor
// depends on clint_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clint_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output clint_pkg::dp_cmd_type        cmd,
   input  wire clint_pkg::dp_status_type status
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_CMP  = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.is_tick ? S_CMP : S_RESP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `CLT_ASSERT_IMPL(a_no_overlap, clock, reset, req_ready, !rsp_valid)
   `CLT_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == S_EXEC)
   `CLT_ASSERT_NEXT(a_tick_cmp, clock, reset, cmd.exec && status.is_tick, cmd.cmp)

endmodule

`default_nettype wire

>>> rtl/clint_dp.sv
// datapath: time counter, compare registers, pending bits, read mux
// depends on clint_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clint_dp #(
   parameter int unsigned HARTS        = 4,
   parameter int unsigned SOFT_BASE    = 0,
   parameter int unsigned COMPARE_BASE = 16384,
   parameter int unsigned TIME_OFFSET  = 49144
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire clint_pkg::dp_cmd_type     cmd,
   output clint_pkg::dp_status_type       status,
   input  wire clint_pkg::req_payload_type req_payload,
   output clint_pkg::rsp_payload_type     rsp_payload
);

   localparam int HW       = (HARTS > 1) ? $clog2(HARTS) : 1;
   localparam int SOFT_END = SOFT_BASE + 4 * HARTS;
   localparam int CMP_END  = COMPARE_BASE + 8 * HARTS;

   clint_pkg::req_payload_type req_ff;
   logic [63:0]      time_ff;
   logic [63:0]      cmp_ff [HARTS];
   logic [HARTS-1:0] soft_ff;
   logic [HARTS-1:0] timer_ff;
   logic [63:0]      rdata_ff;

   logic [63:0]      rdata_in;
   logic [63:0]      mask;
   logic [63:0]      wdata;
   logic             soft_hit;
   logic             cmp_hit;
   logic             time_hit;
   logic [15:0]      soft_off;
   logic [15:0]      cmp_off;
   logic [HW-1:0]    soft_id;
   logic [HW-1:0]    cmp_id;
   logic [63:0]      rvalue;
   logic [63:0]      rmasked;
   logic             rsign;
   logic [31:0]      soft_wide;
   logic [31:0]      timer_wide;

   // address decode, first match wins
   always_comb begin
      soft_hit = (32'(req_ff.addr) >= SOFT_BASE) && (32'(req_ff.addr) < SOFT_END);
      cmp_hit  = !soft_hit && (32'(req_ff.addr) >= COMPARE_BASE)
                 && (32'(req_ff.addr) < CMP_END);
      time_hit = !soft_hit && !cmp_hit && (32'(req_ff.addr) == TIME_OFFSET);
      soft_off = req_ff.addr - 16'(SOFT_BASE);
      cmp_off  = req_ff.addr - 16'(COMPARE_BASE);
      soft_id  = soft_off[HW+1:2];
      cmp_id   = cmp_off[HW+2:3];
      mask     = clint_pkg::size_mask(req_ff.access_size);
      wdata    = req_ff.write_data & mask;
   end

   // read value with size masking and extension
   always_comb begin
      rvalue = '0;
      if (soft_hit) begin
         rvalue = {63'd0, soft_ff[soft_id]};
      end else if (cmp_hit) begin
         rvalue = cmp_ff[cmp_id];
      end else if (time_hit) begin
         rvalue = time_ff;
      end
      rmasked = rvalue & mask;
      unique case (req_ff.access_size)
         clint_pkg::SIZE_BYTE: rsign = rmasked[7];
         clint_pkg::SIZE_HALF: rsign = rmasked[15];
         clint_pkg::SIZE_WORD: rsign = rmasked[31];
         default:              rsign = 1'b0;
      endcase
      rdata_in = '0;
      if (req_ff.req_type == clint_pkg::REQ_READ) begin
         rdata_in = (req_ff.sign_extend && rsign) ? (rmasked | ~mask) : rmasked;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
      end
      if (cmd.exec) begin
         rdata_ff <= rdata_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= '0;
         soft_ff  <= '0;
         timer_ff <= '0;
         for (int i = 0; i < int'(HARTS); i++) begin
            cmp_ff[i] <= '0;
         end
      end else begin
         if (cmd.exec) begin
            unique case (req_ff.req_type)
               clint_pkg::REQ_TICK: begin
                  time_ff <= time_ff + 64'd1;
               end
               clint_pkg::REQ_WRITE: begin
                  if (soft_hit) begin
                     soft_ff[soft_id] <= |wdata;
                  end else if (cmp_hit) begin
                     cmp_ff[cmp_id] <= wdata;
                  end else if (time_hit) begin
                     time_ff <= wdata;
                  end
               end
               default: begin
               end
            endcase
         end
         if (cmd.cmp) begin
            for (int i = 0; i < int'(HARTS); i++) begin
               timer_ff[i] <= (time_ff >= cmp_ff[i]);
            end
         end
      end
   end

   assign status.is_tick = (req_ff.req_type == clint_pkg::REQ_TICK);

   assign soft_wide  = 32'(soft_ff);
   assign timer_wide = 32'(timer_ff);

   assign rsp_payload.read_data     = rdata_ff;
   assign rsp_payload.soft_pending  = soft_wide[clint_pkg::PEND_W-1:0];
   assign rsp_payload.timer_pending = timer_wide[clint_pkg::PEND_W-1:0];

   `CLT_ASSERT_NEXT(a_tick_inc, clock, reset, cmd.exec && status.is_tick, time_ff == $past(time_ff) + 64'd1)
   `CLT_ASSERT_NEXT(a_rd_zero, clock, reset, cmd.exec && req_ff.req_type != clint_pkg::REQ_READ, rdata_ff == 64'd0)

endmodule

`default_nettype wire

>>> rtl/core_local_timer_interruptor_core.sv
// core-local interruptor: one request in, one response out, one at a time
// steps: a read or write runs exec then response; a tick runs exec, compare, response
// the next request is accepted the cycle after the response is taken,
//   as set by the controller sequence
// reset: synchronous active high, clears time, compares and pending bits
`timescale 1ns / 1ps
`default_nettype none

module core_local_timer_interruptor_core #(
   parameter int unsigned HARTS        = 4,
   parameter int unsigned SOFT_BASE    = 0,
   parameter int unsigned COMPARE_BASE = 16384,
   parameter int unsigned TIME_OFFSET  = 49144
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request channel
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire clint_pkg::req_payload_type req_payload,
   // response channel
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output clint_pkg::rsp_payload_type      rsp_payload
);

   // command and status between controller and datapath
   clint_pkg::dp_cmd_type    cmd;
   clint_pkg::dp_status_type status;

   // controller walks idle -> exec -> (compare on ticks) -> response
   clint_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath holds the request, the timer state and the registered read data;
   // compare writes only show in timer pending after the next tick's compare step
   clint_dp #(
      .HARTS        (HARTS),
      .SOFT_BASE    (SOFT_BASE),
      .COMPARE_BASE (COMPARE_BASE),
      .TIME_OFFSET  (TIME_OFFSET)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
